FILE: hdl/positional_list_store_defines.svh
// Assertion macros shared by the positional list store RTL.
// No dependencies; included by the top level only.
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PLS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/pls_pkg.sv
// Shared types, operation and status codes for the positional list store.
// No dependencies; imported by every module of the block.
package pls_pkg;

  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int POS_W     = 8;
  localparam int ST_W      = 2;
  localparam int CNT_OUT_W = 8;
  localparam int FAN       = 4;

  localparam logic [OP_W-1:0] OP_INS_AT   = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND   = 3'd1;
  localparam logic [OP_W-1:0] OP_PREPEND  = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE    = 3'd3;
  localparam logic [OP_W-1:0] OP_REM_AT   = 3'd4;
  localparam logic [OP_W-1:0] OP_REM_END  = 3'd5;
  localparam logic [OP_W-1:0] OP_REM_FRNT = 3'd6;
  localparam logic [OP_W-1:0] OP_COUNT    = 3'd7;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  // Broadcast command seen by every cell.
  typedef struct packed {
    logic ins;
    logic wr;
    logic rem;
  } pls_cmd_t;

  // Levels of a FAN-ary tree needed to cover n leaves.
  function automatic int pls_levels(input int n);
    int lv;
    int span;
    lv   = 0;
    span = 1;
    for (int k = 0; k < 16; k++) begin
      if (span < n) begin
        span = span * FAN;
        lv   = lv + 1;
      end
    end
    return lv;
  endfunction

endpackage

FILE: hdl/pls_cell.sv
// One list slot: holds a word and shifts with its neighbors on insert/remove.
// Depends on pls_pkg.
module pls_cell import pls_pkg::*; #(
  parameter int IW  = 7,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  pls_cmd_t          cmd,
  input  logic [IW-1:0]     pos,
  input  logic [DATA_W-1:0] value_in,
  input  logic [DATA_W-1:0] left_val,
  input  logic [DATA_W-1:0] right_val,
  output logic [DATA_W-1:0] val,
  output logic [DATA_W-1:0] tap
);

  logic [DATA_W-1:0] val_r, val_nxt;
  logic [DATA_W-1:0] tap_r, tap_nxt;
  logic              hit, after;

  assign hit   = (pos == IW'(IDX));
  assign after = (pos < IW'(IDX));

  always_comb begin
    val_nxt = val_r;
    if (cmd.ins) begin
      if (after) begin
        val_nxt = left_val;
      end else if (hit) begin
        val_nxt = value_in;
      end
    end else if (cmd.wr && hit) begin
      val_nxt = value_in;
    end else if (cmd.rem && (after || hit)) begin
      val_nxt = right_val;
    end
    tap_nxt = (cmd.rem && hit) ? val_r : '0;
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    tap_r <= tap_nxt;
  end

  assign val = val_r;
  assign tap = tap_r;

endmodule

FILE: hdl/pls_or_tree.sv
// Registered 4-ary OR tree that collects the one removed word from the cells.
// Depends on pls_pkg.
module pls_or_tree import pls_pkg::*; #(
  parameter int N = 128
) (
  input  logic              clk,
  input  logic [DATA_W-1:0] leaf [N],
  output logic [DATA_W-1:0] root
);

  localparam int LVL    = pls_levels(N);
  localparam int LEAVES = FAN ** LVL;
  localparam int INNER  = (LEAVES - 1) / (FAN - 1);

  logic [DATA_W-1:0] node_r [INNER];

  for (genvar j = 0; j < INNER; j++) begin : g_node
    logic [DATA_W-1:0] kid [FAN];
    logic [DATA_W-1:0] node_nxt;

    for (genvar c = 0; c < FAN; c++) begin : g_kid
      localparam int K = FAN * j + c + 1;
      if (K < INNER) begin : g_inner
        assign kid[c] = node_r[K];
      end else if (K - INNER < N) begin : g_leaf
        assign kid[c] = leaf[K - INNER];
      end else begin : g_pad
        assign kid[c] = '0;
      end
    end

    always_comb begin
      node_nxt = '0;
      for (int c = 0; c < FAN; c++) begin
        node_nxt = node_nxt | kid[c];
      end
    end

    always_ff @(posedge clk) begin
      node_r[j] <= node_nxt;
    end
  end

  assign root = node_r[0];

endmodule

FILE: hdl/positional_list_store.sv
// Top level of the positional list store: decode, count, cell row and output pipe.
// Depends on pls_pkg, pls_cell, pls_or_tree and positional_list_store_defines.svh.
`include "positional_list_store_defines.svh"

// Ordered list of up to CAPACITY signed 32-bit words held in a row of cells.
// A request beat is taken on any edge where start is high and busy is low;
// busy stays low, so a new beat may follow every cycle. Every beat gives
// exactly one result beat, marked by out_strobe for one cycle. The removed
// word passes the tap register of its cell and then every level of the
// registered OR tree, LVL = ceil(log4(CAPACITY)) levels in all, and status
// and count are delayed alongside it; results leave in request order and
// the receiver cannot stall them, so sample them on the strobe. The list
// itself is updated in the cycle a beat is taken: every cell compares its
// own slot with the request position and holds, loads the new word, or takes
// its left or right neighbor's word, so entries behind the position shift in
// one step. out_count carries the low 8 bits of the count after the request.
// Entries come up undefined after reset; only the count and the result valid bits are cleared.
module positional_list_store import pls_pkg::*; #(
  parameter int CAPACITY = 128
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [OP_W-1:0]         in_operation,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [DATA_W-1:0] in_value_in,
  output logic                    out_strobe,
  output logic [ST_W-1:0]         out_status,
  output logic signed [DATA_W-1:0] out_value_out,
  output logic [CNT_OUT_W-1:0]    out_count
);

  localparam int IW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CW > POS_W) ? CW : POS_W;
  localparam int LVL   = pls_levels(CAPACITY);

  logic              acc;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CMP_W-1:0]  pos_ext, cnt_ext;
  logic              full, empty;
  logic              ins_ok, wr_ok, rem_ok;
  logic [IW-1:0]     sel_pos;
  logic [ST_W-1:0]   st;
  pls_cmd_t          cmd;

  logic [DATA_W-1:0] cell_val [CAPACITY];
  logic [DATA_W-1:0] cell_tap [CAPACITY];
  logic [DATA_W-1:0] root;

  logic                 vld_pipe_r [LVL+1];
  logic [ST_W-1:0]      st_pipe_r  [LVL+1];
  logic [CNT_OUT_W-1:0] cnt_pipe_r [LVL+1];

  // Cells update on the edge that takes the beat and the tree is a pipeline: never hold off.
  assign busy = 1'b0;
  assign acc  = start && !busy;

  assign pos_ext = CMP_W'(in_position);
  assign cnt_ext = CMP_W'(cnt_r);
  assign full    = (cnt_r == CW'(CAPACITY));
  assign empty   = (cnt_r == '0);

  // Decode the request into a status, a slot and one of insert/write/remove.
  always_comb begin
    st      = ST_OK;
    ins_ok  = 1'b0;
    wr_ok   = 1'b0;
    rem_ok  = 1'b0;
    sel_pos = '0;
    case (in_operation)
      OP_INS_AT: begin
        if (full) begin
          st = ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          st = ST_RANGE;
        end else begin
          ins_ok  = 1'b1;
          sel_pos = IW'(pos_ext);
        end
      end
      OP_APPEND: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          ins_ok  = 1'b1;
          sel_pos = IW'(cnt_r);
        end
      end
      OP_PREPEND: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      OP_WRITE: begin
        if (pos_ext >= cnt_ext) begin
          st = ST_RANGE;
        end else begin
          wr_ok   = 1'b1;
          sel_pos = IW'(pos_ext);
        end
      end
      OP_REM_AT: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          st = ST_RANGE;
        end else begin
          rem_ok  = 1'b1;
          sel_pos = IW'(pos_ext);
        end
      end
      OP_REM_END: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          rem_ok  = 1'b1;
          sel_pos = IW'(cnt_r - CW'(1));
        end
      end
      OP_REM_FRNT: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          rem_ok = 1'b1;
        end
      end
      OP_COUNT: begin
        st = ST_OK;
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  // Drop the command on cycles without a beat so cells hold and taps clear.
  assign cmd.ins = acc && ins_ok;
  assign cmd.wr  = acc && wr_ok;
  assign cmd.rem = acc && rem_ok;

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.ins) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.rem) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Row of cells; the ends see zero as their missing neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_val, right_val;

    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end

    pls_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .pos       (sel_pos),
      .value_in  (in_value_in),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (cell_val[i]),
      .tap       (cell_tap[i])
    );
  end

  // Only the removed slot taps a nonzero word, so an OR gathers it.
  pls_or_tree #(
    .N (CAPACITY)
  ) u_tree (
    .clk  (clk),
    .leaf (cell_tap),
    .root (root)
  );

  // Carry status and count alongside the tree so they meet the removed word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LVL; k++) begin
        vld_pipe_r[k] <= 1'b0;
      end
    end else begin
      vld_pipe_r[0] <= acc;
      for (int k = 1; k <= LVL; k++) begin
        vld_pipe_r[k] <= vld_pipe_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    st_pipe_r[0]  <= st;
    cnt_pipe_r[0] <= CNT_OUT_W'(cnt_nxt);
    for (int k = 1; k <= LVL; k++) begin
      st_pipe_r[k]  <= st_pipe_r[k-1];
      cnt_pipe_r[k] <= cnt_pipe_r[k-1];
    end
  end

  assign out_strobe    = vld_pipe_r[LVL];
  assign out_status    = st_pipe_r[LVL];
  assign out_count     = cnt_pipe_r[LVL];
  assign out_value_out = root;

  `PLS_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(CAPACITY), "count above capacity")
  `PLS_ASSERT_NEXT(a_ins_grows, clk, rst_n, cmd.ins, cnt_r == $past(cnt_r) + CW'(1), "insert lost count")
  `PLS_ASSERT_NEXT(a_rem_drops, clk, rst_n, cmd.rem, cnt_r == $past(cnt_r) - CW'(1), "remove lost count")
  `PLS_ASSERT_IMPL(a_err_zero, clk, rst_n, out_strobe && (out_status != ST_OK), out_value_out == '0, "value on failed beat")

endmodule
